@@ src/lfrc_pkg.sv @@
// ----------------------------------------------------------------------------
// lfrc_pkg
// Shared types, widths and constants of the line follower route controller.
// ----------------------------------------------------------------------------
package lfrc_pkg;

  localparam int SENSOR_COUNT = 5;
  localparam int ROUTE_STEPS  = 16;
  localparam int ROUTE_IDX_W  = $clog2(ROUTE_STEPS);

  localparam int KP_W     = 7;
  localparam int BASE_W   = 8;
  localparam int ROUTE_W  = 32;
  localparam int TICKS_W  = 12;
  localparam int PWM_W    = 8;
  localparam int COUNT_W  = 3;
  localparam int SUM_W    = 5;
  localparam int SUMMAG_W = 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // shared restoring divider: 14-bit dividend, 5-bit divisor
  localparam int DIV_W     = 14;
  localparam int DEN_W     = 5;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int CORR_W    = 9;
  localparam int VEL_W     = 11;
  localparam int VMAG_W    = 10;

  // constant scaling: floor(y/d) = (y * ceil(2^19/d)) >> 19, exact for any 14-bit y
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 19;
  localparam int SCALE_W     = DIV_W + RECIP_W - RECIP_SHIFT;

  localparam logic [KP_W-1:0]    KP_RESET       = 7'd25;
  localparam logic [BASE_W-1:0]  BASE_RESET     = 8'd50;
  localparam logic [ROUTE_W-1:0] ROUTE_RESET    = 32'h4746_4746;
  localparam logic [TICKS_W-1:0] STRAIGHT_RESET = 12'd1300;
  localparam logic [TICKS_W-1:0] TURN_RESET     = 12'd1000;

  localparam logic [COUNT_W-1:0] LINE_MIN = 3'd3;
  localparam logic [PWM_W-1:0]   PWM_MAX  = 8'd255;

  // left scale 1.1 = 11/10, right turn 1.2*1.1 = 33/25, fast side 1.2 = 6/5
  localparam logic [DIV_W-1:0] LEFT_GAIN_NUM = 14'd11;
  localparam logic [DEN_W-1:0] LEFT_GAIN_DEN = 5'd10;
  localparam logic [DIV_W-1:0] TURN_GAIN_NUM = 14'd33;
  localparam logic [DEN_W-1:0] TURN_GAIN_DEN = 5'd25;
  localparam logic [DIV_W-1:0] FAST_GAIN_NUM = 14'd6;
  localparam logic [DEN_W-1:0] FAST_GAIN_DEN = 5'd5;

  localparam logic [RECIP_W-1:0] LEFT_GAIN_RECIP = 17'd52429;
  localparam logic [RECIP_W-1:0] TURN_GAIN_RECIP = 17'd20972;
  localparam logic [RECIP_W-1:0] FAST_GAIN_RECIP = 17'd104858;

  localparam logic signed [3:0] LINE_WEIGHT [SENSOR_COUNT] = '{4'sd5, 4'sd2, 4'sd0,
                                                                -4'sd2, -4'sd5};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP,
    CFG_BASE_SPEED,
    CFG_ROUTE,
    CFG_STRAIGHT_TICKS,
    CFG_TURN_TICKS
  } cfg_idx_t;

  typedef enum logic [1:0] {
    STEP_STRAIGHT,
    STEP_SPIN,
    STEP_RIGHT,
    STEP_LEFT
  } step_t;

  typedef enum logic [1:0] {
    PH_TRACK,
    PH_BLIND,
    PH_WAIT
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_CORR,
    ST_CORR,
    ST_DIV_LEFT,
    ST_DIV_RIGHT,
    ST_OUT
  } seq_t;

  function automatic logic [PWM_W-1:0] sat_pwm(input logic [DIV_W-1:0] v);
    sat_pwm = (v > DIV_W'(PWM_MAX)) ? PWM_MAX : v[PWM_W-1:0];
  endfunction

endpackage

@@ src/lfrc_if.sv @@
// ----------------------------------------------------------------------------
// lfrc_if
// Valid/ready channels of the line follower route controller.
// ----------------------------------------------------------------------------
interface lfrc_in_if import lfrc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [SENSOR_COUNT-1:0] sensors;

  modport source (output valid, output sensors, input ready);
  modport sink   (input valid, input sensors, output ready);
endinterface

interface lfrc_out_if import lfrc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               left_reverse;
  logic [PWM_W-1:0]   left_pwm;
  logic               right_reverse;
  logic [PWM_W-1:0]   right_pwm;
  logic [COUNT_W-1:0] line_count;

  modport source (output valid, output left_reverse, output left_pwm,
                  output right_reverse, output right_pwm, output line_count,
                  input ready);
  modport sink   (input valid, input left_reverse, input left_pwm,
                  input right_reverse, input right_pwm, input line_count,
                  output ready);
endinterface

interface lfrc_cfg_if import lfrc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/line_follower_route_controller_top.sv @@
// ----------------------------------------------------------------------------
// line_follower_route_controller_top
// Five-sensor proportional line follower with a programmable route.
// ----------------------------------------------------------------------------
// Each input transaction is one control tick carrying the raw sensor bits and
// yields exactly one motor command transaction. The error normalization by the
// line count runs through one shared restoring divider that retires one
// quotient bit per cycle; the fixed 1.1, 1.32 and 1.2 scalings are reciprocal
// multiplies. A lost line yields the stop command without any scaling, a
// route step drive takes one left scaling pass (a left turn adds a pass that
// scales its fast right side separately), and a tracking tick runs its steps
// (normalization, velocity forming, then left scaling). in_ch.ready is high
// only while the sequencer is idle; a finished command waits in the output
// register, so the next tick is taken while the previous command is still
// unclaimed, and the sequencer holds in its last cycle while that register is
// still occupied. Configuration writes are always accepted and must only
// arrive while the block is idle.
// ----------------------------------------------------------------------------
module line_follower_route_controller_top
  import lfrc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  lfrc_in_if.sink          in_ch,
  lfrc_out_if.source       out_ch,
  lfrc_cfg_if.sink         cfg_ch
);

  // configuration
  logic [KP_W-1:0]    kp_r;
  logic [BASE_W-1:0]  base_r;
  logic [ROUTE_W-1:0] route_r;
  logic [TICKS_W-1:0] straight_r;
  logic [TICKS_W-1:0] turn_r;

  // route state
  phase_t                 phase_r, phase_nxt;
  logic [ROUTE_IDX_W-1:0] ridx_r, ridx_nxt;
  logic [TICKS_W-1:0]     ticks_r, ticks_nxt;
  step_t                  step_r, step_nxt;

  // sequencer and divider
  seq_t                 seq_r, seq_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [DEN_W-1:0]     den_r, den_nxt;
  logic [DIV_CNT_W-1:0] dcnt_r, dcnt_nxt;
  logic                 neg_r, neg_nxt;
  logic                 rdiv_r, rdiv_nxt;

  // result under construction
  logic               lrev_r, lrev_nxt;
  logic [PWM_W-1:0]   lpwm_r, lpwm_nxt;
  logic               rrev_r, rrev_nxt;
  logic [PWM_W-1:0]   rpwm_r, rpwm_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic               out_lrev_r;
  logic [PWM_W-1:0]   out_lpwm_r;
  logic               out_rrev_r;
  logic [PWM_W-1:0]   out_rpwm_r;
  logic [COUNT_W-1:0] out_cnt_r;
  logic               out_load;

  // sensor analysis
  logic [COUNT_W-1:0]  line_cnt;
  logic signed [SUM_W-1:0] line_sum;
  logic [SUMMAG_W-1:0] sum_mag;
  logic                wait_bit;
  phase_t              ph_eff;

  // step drive
  logic [DIV_W-1:0]  st_lnum;
  logic [DEN_W-1:0]  st_lden;
  logic              st_lrev;
  logic [PWM_W-1:0]  st_rmag;

  // divider step
  logic [DEN_W:0]    trial;
  logic              div_ge;
  logic [DEN_W:0]    trial_sub;
  logic [DEN_W-1:0]  rem_step;
  logic [DIV_W-1:0]  quo_step;
  logic              div_last;

  // constant scaling
  logic [RECIP_W-1:0]       recip;
  logic [DIV_W+RECIP_W-1:0] scale_prod;
  logic [SCALE_W-1:0]       scale_quo;

  // tracking correction
  logic signed [VEL_W-1:0] base_s, corr_s, vl_s, vr_s, vl_abs, vr_abs;
  logic [VMAG_W-1:0]       vl_mag, vr_mag;

  // route bookkeeping
  step_t                route_step;
  logic [ROUTE_IDX_W:0] ridx_inc;
  logic [TICKS_W-1:0]   load_ticks;
  logic [TICKS_W-1:0]   ticks_dec;

  logic in_fire;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (seq_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.left_reverse  = out_lrev_r;
  assign out_ch.left_pwm      = out_lpwm_r;
  assign out_ch.right_reverse = out_rrev_r;
  assign out_ch.right_pwm     = out_rpwm_r;
  assign out_ch.line_count    = out_cnt_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r       <= KP_RESET;
      base_r     <= BASE_RESET;
      route_r    <= ROUTE_RESET;
      straight_r <= STRAIGHT_RESET;
      turn_r     <= TURN_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_KP:             kp_r       <= cfg_ch.data[KP_W-1:0];
        CFG_BASE_SPEED:     base_r     <= cfg_ch.data[BASE_W-1:0];
        CFG_ROUTE:          route_r    <= cfg_ch.data[ROUTE_W-1:0];
        CFG_STRAIGHT_TICKS: straight_r <= cfg_ch.data[TICKS_W-1:0];
        CFG_TURN_TICKS:     turn_r     <= cfg_ch.data[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // count line sensors and form the weighted error
  always_comb begin
    line_cnt = '0;
    line_sum = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (!in_ch.sensors[i]) begin
        line_cnt = line_cnt + COUNT_W'(1);
        line_sum = line_sum + SUM_W'(LINE_WEIGHT[i]);
      end
    end
    sum_mag = line_sum[SUM_W-1] ? SUMMAG_W'(-line_sum) : SUMMAG_W'(line_sum);
  end

  assign wait_bit = (step_r == STEP_RIGHT) ? in_ch.sensors[3] : in_ch.sensors[1];

  always_comb begin
    case (phase_r)
      PH_WAIT:  ph_eff = wait_bit ? PH_TRACK : PH_WAIT;
      PH_BLIND: ph_eff = PH_BLIND;
      default:  ph_eff = PH_TRACK;
    endcase
  end

  // drive of the active route step, left side before division
  always_comb begin
    case (step_r)
      STEP_STRAIGHT: begin
        st_lnum = DIV_W'(base_r) * LEFT_GAIN_NUM;
        st_lden = LEFT_GAIN_DEN;
        st_lrev = 1'b0;
        st_rmag = base_r;
      end
      STEP_SPIN: begin
        st_lnum = DIV_W'(base_r) * LEFT_GAIN_NUM;
        st_lden = LEFT_GAIN_DEN;
        st_lrev = 1'b1;
        st_rmag = base_r;
      end
      STEP_RIGHT: begin
        st_lnum = DIV_W'(base_r) * TURN_GAIN_NUM;
        st_lden = TURN_GAIN_DEN;
        st_lrev = 1'b0;
        st_rmag = base_r >> 1;
      end
      default: begin
        st_lnum = DIV_W'(base_r >> 1) * LEFT_GAIN_NUM;
        st_lden = LEFT_GAIN_DEN;
        st_lrev = 1'b0;
        st_rmag = '0;
      end
    endcase
  end

  // one restoring division step
  assign trial     = {rem_r, quo_r[DIV_W-1]};
  assign div_ge    = (trial >= {1'b0, den_r});
  assign trial_sub = trial - {1'b0, den_r};
  assign rem_step  = div_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
  assign quo_step  = {quo_r[DIV_W-2:0], div_ge};
  assign div_last  = (dcnt_r == DIV_CNT_W'(DIV_W - 1));

  // divide the held value by a fixed scale denominator
  always_comb begin
    case (den_r)
      LEFT_GAIN_DEN: recip = LEFT_GAIN_RECIP;
      TURN_GAIN_DEN: recip = TURN_GAIN_RECIP;
      default:       recip = FAST_GAIN_RECIP;
    endcase
  end

  assign scale_prod = (DIV_W+RECIP_W)'(quo_r) * (DIV_W+RECIP_W)'(recip);
  assign scale_quo  = scale_prod[DIV_W+RECIP_W-1 -: SCALE_W];

  // tracking velocities from the normalized correction
  assign base_s = VEL_W'(base_r);
  assign corr_s = neg_r ? -VEL_W'(quo_r[CORR_W-1:0]) : VEL_W'(quo_r[CORR_W-1:0]);
  assign vl_s   = base_s + corr_s;
  assign vr_s   = base_s - corr_s;
  assign vl_abs = vl_s[VEL_W-1] ? -vl_s : vl_s;
  assign vr_abs = vr_s[VEL_W-1] ? -vr_s : vr_s;
  assign vl_mag = vl_abs[VMAG_W-1:0];
  assign vr_mag = vr_abs[VMAG_W-1:0];

  // next route step
  assign route_step = step_t'(route_r[{ridx_r, 1'b0} +: 2]);
  assign ridx_inc   = {1'b0, ridx_r} + (ROUTE_IDX_W+1)'(1);
  assign load_ticks = (route_step == STEP_STRAIGHT) ? straight_r : turn_r;
  assign ticks_dec  = (ticks_r != '0) ? ticks_r - TICKS_W'(1) : '0;

  assign out_load = (seq_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    seq_nxt       = seq_r;
    phase_nxt     = phase_r;
    ridx_nxt      = ridx_r;
    ticks_nxt     = ticks_r;
    step_nxt      = step_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    dcnt_nxt      = dcnt_r;
    neg_nxt       = neg_r;
    rdiv_nxt      = rdiv_r;
    lrev_nxt      = lrev_r;
    lpwm_nxt      = lpwm_r;
    rrev_nxt      = rrev_r;
    rpwm_nxt      = rpwm_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (seq_r)
      ST_IDLE: begin
        if (in_fire) begin
          cnt_nxt = line_cnt;
          case (ph_eff)
            PH_WAIT, PH_BLIND: begin
              if (ph_eff == PH_BLIND) begin
                ticks_nxt = ticks_dec;
                phase_nxt = PH_BLIND;
                if (ticks_dec == '0) begin
                  phase_nxt = (step_r == STEP_STRAIGHT) ? PH_TRACK : PH_WAIT;
                end
              end
              quo_nxt  = st_lnum;
              den_nxt  = st_lden;
              lrev_nxt = st_lrev;
              rrev_nxt = 1'b0;
              rpwm_nxt = st_rmag;
              rdiv_nxt = (step_r == STEP_LEFT);
              seq_nxt  = ST_DIV_LEFT;
            end
            default: begin
              phase_nxt = PH_TRACK;
              if (line_cnt >= LINE_MIN) begin
                quo_nxt  = DIV_W'(kp_r) * DIV_W'(sum_mag);
                den_nxt  = DEN_W'(line_cnt);
                rem_nxt  = '0;
                dcnt_nxt = '0;
                neg_nxt  = line_sum[SUM_W-1];
                seq_nxt  = ST_DIV_CORR;
              end else begin
                // line lost: stop for this tick, arm the next route step
                lrev_nxt  = 1'b0;
                lpwm_nxt  = '0;
                rrev_nxt  = 1'b0;
                rpwm_nxt  = '0;
                step_nxt  = route_step;
                ticks_nxt = load_ticks;
                ridx_nxt  = (ridx_inc >= (ROUTE_IDX_W+1)'(ROUTE_STEPS)) ?
                            '0 : ridx_inc[ROUTE_IDX_W-1:0];
                if (load_ticks != '0) begin
                  phase_nxt = PH_BLIND;
                end else begin
                  phase_nxt = (route_step == STEP_STRAIGHT) ? PH_TRACK : PH_WAIT;
                end
                seq_nxt = ST_OUT;
              end
            end
          endcase
        end
      end
      ST_DIV_CORR: begin
        quo_nxt  = quo_step;
        rem_nxt  = rem_step;
        dcnt_nxt = dcnt_r + DIV_CNT_W'(1);
        if (div_last) begin
          seq_nxt = ST_CORR;
        end
      end
      ST_CORR: begin
        lrev_nxt = vl_s[VEL_W-1];
        rrev_nxt = vr_s[VEL_W-1];
        rpwm_nxt = sat_pwm(DIV_W'(vr_mag));
        quo_nxt  = DIV_W'(vl_mag) * LEFT_GAIN_NUM;
        den_nxt  = LEFT_GAIN_DEN;
        rdiv_nxt = 1'b0;
        seq_nxt  = ST_DIV_LEFT;
      end
      ST_DIV_LEFT: begin
        lpwm_nxt = sat_pwm(DIV_W'(scale_quo));
        if (rdiv_r) begin
          // left turn: fast right side needs its own scaling pass
          quo_nxt = DIV_W'(base_r) * FAST_GAIN_NUM;
          den_nxt = FAST_GAIN_DEN;
          seq_nxt = ST_DIV_RIGHT;
        end else begin
          seq_nxt = ST_OUT;
        end
      end
      ST_DIV_RIGHT: begin
        rpwm_nxt = sat_pwm(DIV_W'(scale_quo));
        seq_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          seq_nxt       = ST_IDLE;
        end
      end
      default: begin
        seq_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= ST_IDLE;
      phase_r     <= PH_TRACK;
      ridx_r      <= '0;
      ticks_r     <= '0;
      step_r      <= STEP_STRAIGHT;
      out_valid_r <= 1'b0;
    end else begin
      seq_r       <= seq_nxt;
      phase_r     <= phase_nxt;
      ridx_r      <= ridx_nxt;
      ticks_r     <= ticks_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    dcnt_r <= dcnt_nxt;
    neg_r  <= neg_nxt;
    rdiv_r <= rdiv_nxt;
    lrev_r <= lrev_nxt;
    lpwm_r <= lpwm_nxt;
    rrev_r <= rrev_nxt;
    rpwm_r <= rpwm_nxt;
    cnt_r  <= cnt_nxt;
  end

  // hold the command until the sink takes it
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_lrev_r <= lrev_r;
      out_lpwm_r <= lpwm_r;
      out_rrev_r <= rrev_r;
      out_rpwm_r <= rpwm_r;
      out_cnt_r  <= cnt_r;
    end
  end

endmodule

@@ src/lfrc_checker.sv @@
// ----------------------------------------------------------------------------
// lfrc_checker
// Port-level checks of the line follower route controller.
// ----------------------------------------------------------------------------
module lfrc_checker
  import lfrc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               left_reverse,
  input logic [PWM_W-1:0]   left_pwm,
  input logic               right_reverse,
  input logic [PWM_W-1:0]   right_pwm,
  input logic [COUNT_W-1:0] line_count
);

  // a pending command stays offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("command dropped before its transaction completed");

  // a stalled command holds its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable({left_reverse, left_pwm, right_reverse, right_pwm, line_count}))
    else $error("command payload changed while stalled");

  // the shared divider serves one tick at a time
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("tick accepted while previous tick still in work");

  // only five sensors can see the line
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> line_count <= COUNT_W'(SENSOR_COUNT))
    else $error("line count out of range");

endmodule

bind line_follower_route_controller_top lfrc_checker u_lfrc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .left_reverse  (out_ch.left_reverse),
  .left_pwm      (out_ch.left_pwm),
  .right_reverse (out_ch.right_reverse),
  .right_pwm     (out_ch.right_pwm),
  .line_count    (out_ch.line_count)
);
